FILE: sv/text_console_cursor_scroll_core_macros.svh
// Assertion macros for the text console core.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TCCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text console core: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define TCCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text console core: next-cycle check failed");

`endif

FILE: sv/tccs_pkg.sv
// Shared types, constants and helpers for the text console core.
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;

  localparam logic [7:0] BLANK_CHAR     = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [7:0] ASCII_ZERO     = 8'd48;
  localparam logic [7:0] ASCII_HEX_BASE = 8'd55;
  localparam logic [3:0] MAX_HEX_DIGITS = 4'd8;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_HEX   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // Upper-case hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    if (nib < 4'd10) begin
      hex_char = wide + ASCII_ZERO;
    end else begin
      hex_char = wide + ASCII_HEX_BASE;
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/text_console_cursor_scroll_core.sv
// Top level of the text console core: screen store, cursor and sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Character console with a SCREEN_ROWS x SCREEN_COLUMNS screen store (one byte
// per cell) and a cursor. Each input beat is one command: write a character
// (code 10 is newline), write up to 8 upper-case hex digits of hex_value, clear
// the screen, or read back one cell. Each command returns exactly one output
// beat with the cursor position after the command, a scrolled flag and, for a
// read, the stored byte. The block handles one command at a time; in_ready is
// high only while it is idle. Steps: a character is written in the put state;
// a hex write puts one digit per cycle through the character path (a scroll
// holds it); a read does the address multiply, registered memory read, capture
// and result in turn; a clear blanks one cell per cycle through the single
// write port. A scroll, triggered when the cursor runs past the last row,
// copies the store up one row, one cell per cycle (read port and write port
// working in parallel, each write in the cycle after its read), and then
// blanks the last row one cell per cycle once the last copy write is done.
// After reset the block runs a clearing pass, filling the store with spaces,
// before in_ready first rises. A single address counter and adder serve every
// sweep; the cursor keeps a running linear address so no multiplier sits in
// the character path.
module text_console_cursor_scroll_core #(
  parameter int SCREEN_COLUMNS = tccs_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tccs_pkg::DEF_SCREEN_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  char_code,
  input  wire logic [31:0] hex_value,
  input  wire logic [3:0]  hex_digits,
  input  wire logic [4:0]  cell_row,
  input  wire logic [6:0]  cell_column,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       read_char,
  output logic [4:0]       cursor_row,
  output logic [6:0]       cursor_column,
  output logic             scrolled
);

  localparam int CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int MOVED  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_MOVED = ADDR_W'(MOVED - 1);
  localparam logic [ADDR_W-1:0] MOVED_ADDR = ADDR_W'(MOVED);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W:0]    COL_LIMIT  = (COL_W + 1)'(SCREEN_COLUMNS);

  typedef enum logic [3:0] {
    S_INIT_FILL,
    S_IDLE,
    S_PUT,
    S_SCROLL_COPY,
    S_SCROLL_BLANK,
    S_CLEAR_FILL,
    S_READ,
    S_READ_WAIT,
    S_OUT
  } state_t;

  state_t state;

  // Screen store: one write port, one registered read port.
  logic [7:0]        mem [CELLS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  // Cursor: row/column plus running linear address and row start.
  logic [COL_W-1:0]  cursor_x;
  logic [ROW_W-1:0]  cursor_y;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] row_base;

  // Sweep counter and the pending copy write, which follows the read in the next cycle.
  logic [ADDR_W-1:0] scan;
  logic [ADDR_W-1:0] scan_src;
  logic              copy_pend;
  logic [ADDR_W-1:0] copy_waddr;

  // Latched command.
  logic              hex_mode;
  logic [7:0]        char_r;
  logic [31:0]       value_r;
  logic [3:0]        digits_left;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_ok;

  logic [3:0]        digits_sat;
  logic [2:0]        dig_idx;
  logic [7:0]        put_char;
  logic              is_newline;
  logic [COL_W:0]    x_inc;
  logic              row_end;
  logic [ADDR_W-1:0] base_next;
  logic [ADDR_W-1:0] rd_addr_next;
  logic              rd_ok_next;

  assign in_ready      = (state == S_IDLE);
  assign out_valid     = (state == S_OUT);
  assign cursor_row    = 5'(cursor_y);
  assign cursor_column = 7'(cursor_x);

  // Character for this step: the latched byte, or the current hex digit.
  assign dig_idx    = 3'(digits_left - 4'd1);
  assign put_char   = hex_mode ? tccs_pkg::hex_char(value_r[dig_idx*4 +: 4]) : char_r;
  assign is_newline = (put_char == tccs_pkg::NEWLINE_CHAR);

  // Advance the cursor; a newline or a full row moves to the next row.
  assign x_inc     = {1'b0, cursor_x} + 1'b1;
  assign row_end   = is_newline || (x_inc == COL_LIMIT);
  assign base_next = row_base + ROW_STRIDE;

  // Scroll copy reads one row ahead of the write.
  assign scan_src  = scan + ROW_STRIDE;

  assign digits_sat = (hex_digits > tccs_pkg::MAX_HEX_DIGITS) ?
                      tccs_pkg::MAX_HEX_DIGITS : hex_digits;

  assign rd_addr_next = ADDR_W'(ADDR_W'(cell_row) * ROW_STRIDE) + ADDR_W'(cell_column);
  assign rd_ok_next   = (32'(cell_row) < 32'(SCREEN_ROWS)) &&
                        (32'(cell_column) < 32'(SCREEN_COLUMNS));

  // Write port arbitration: a pending copy wins over a blanking sweep.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan;
    mem_wdata = tccs_pkg::BLANK_CHAR;
    mem_raddr = (state == S_READ) ? rd_addr : scan_src;
    if (copy_pend) begin
      mem_we    = 1'b1;
      mem_waddr = copy_waddr;
      mem_wdata = mem_rdata;
    end else begin
      case (state)
        S_INIT_FILL, S_CLEAR_FILL, S_SCROLL_BLANK: begin
          mem_we = 1'b1;
        end
        S_PUT: begin
          mem_we    = !is_newline;
          mem_waddr = cur_addr;
          mem_wdata = put_char;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT_FILL;
      scan      <= '0;
      cursor_x  <= '0;
      cursor_y  <= '0;
      cur_addr  <= '0;
      row_base  <= '0;
      copy_pend <= 1'b0;
    end else begin
      copy_pend  <= (state == S_SCROLL_COPY);
      copy_waddr <= scan;
      case (state)
        S_INIT_FILL: begin
          if (scan == LAST_CELL) begin
            state <= S_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            hex_mode  <= 1'b0;
            char_r    <= char_code;
            value_r   <= hex_value;
            read_char <= '0;
            scrolled  <= 1'b0;
            case (tccs_pkg::kind_t'(kind))
              tccs_pkg::KIND_CHAR: begin
                digits_left <= 4'd1;
                state       <= S_PUT;
              end
              tccs_pkg::KIND_HEX: begin
                hex_mode    <= 1'b1;
                digits_left <= digits_sat;
                state       <= (digits_sat == 4'd0) ? S_OUT : S_PUT;
              end
              tccs_pkg::KIND_CLEAR: begin
                cursor_x <= '0;
                cursor_y <= '0;
                cur_addr <= '0;
                row_base <= '0;
                scan     <= '0;
                state    <= S_CLEAR_FILL;
              end
              default: begin
                rd_addr <= rd_addr_next;
                rd_ok   <= rd_ok_next;
                state   <= S_READ;
              end
            endcase
          end
        end

        S_PUT: begin
          if (row_end) begin
            cursor_x <= '0;
            if (cursor_y == LAST_ROW) begin
              // Cursor stays on the last row at column 0; copy the store up.
              cur_addr <= row_base;
              scrolled <= 1'b1;
              scan     <= '0;
              state    <= S_SCROLL_COPY;
            end else begin
              cursor_y <= cursor_y + 1'b1;
              row_base <= base_next;
              cur_addr <= base_next;
            end
          end else begin
            cursor_x <= COL_W'(x_inc);
            cur_addr <= cur_addr + 1'b1;
          end
          if (!(row_end && (cursor_y == LAST_ROW))) begin
            digits_left <= digits_left - 4'd1;
            if (digits_left == 4'd1) begin
              state <= S_OUT;
            end
          end
        end

        S_SCROLL_COPY: begin
          if (scan == LAST_MOVED) begin
            scan  <= MOVED_ADDR;
            state <= S_SCROLL_BLANK;
          end else begin
            scan <= scan + 1'b1;
          end
        end

        S_SCROLL_BLANK: begin
          // Hold while the last copy write still owns the port.
          if (!copy_pend) begin
            if (scan == LAST_CELL) begin
              digits_left <= digits_left - 4'd1;
              state       <= (digits_left == 4'd1) ? S_OUT : S_PUT;
            end else begin
              scan <= scan + 1'b1;
            end
          end
        end

        S_CLEAR_FILL: begin
          if (scan == LAST_CELL) begin
            state <= S_OUT;
          end else begin
            scan <= scan + 1'b1;
          end
        end

        S_READ: begin
          state <= S_READ_WAIT;
        end

        S_READ_WAIT: begin
          read_char <= rd_ok ? mem_rdata : 8'd0;
          state     <= S_OUT;
        end

        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "text_console_cursor_scroll_core_macros.svh"

  // Cursor never leaves the screen.
  `TCCS_ASSERT_NOW(a_cursor_on_screen, 1'b1, (cursor_x < COL_W'(SCREEN_COLUMNS - 1) || cursor_x == COL_W'(SCREEN_COLUMNS - 1)) && (cursor_y <= LAST_ROW))
  // Linear cursor address tracks row start plus column.
  `TCCS_ASSERT_NOW(a_cursor_addr, state != S_INIT_FILL, cur_addr == row_base + ADDR_W'(cursor_x))
  // A copy write always lands at a lower address than the cell being read.
  `TCCS_ASSERT_NOW(a_copy_order, copy_pend && state == S_SCROLL_COPY, copy_waddr < mem_raddr)
  // A taken result frees the block for the next command.
  `TCCS_ASSERT_NEXT(a_out_to_idle, out_valid && out_ready, in_ready && !out_valid)

endmodule

`default_nettype wire

FILE: tb/text_console_result_checker.sv
// Result checker for the text console core: screen mirror, expected beats and comparison.
`timescale 1ns / 1ps

module text_console_result_checker #(
  parameter int SCREEN_COLUMNS = tccs_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tccs_pkg::DEF_SCREEN_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  char_code,
  input  logic [31:0] hex_value,
  input  logic [3:0]  hex_digits,
  input  logic [4:0]  cell_row,
  input  logic [6:0]  cell_column,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  read_char,
  input  logic [4:0]  cursor_row,
  input  logic [6:0]  cursor_column,
  input  logic        scrolled,
  output int          mismatches,
  output int          beats_due
);

  localparam int SCREEN_CELLS = SCREEN_COLUMNS * SCREEN_ROWS;

  typedef struct packed {
    logic [7:0] read_char;
    logic [4:0] row;
    logic [6:0] column;
    logic       scrolled;
  } console_beat_t;

  console_beat_t results_due[$];
  logic [7:0]    screen_copy [SCREEN_CELLS];
  int            cur_row;
  int            cur_col;

  function automatic void blank_screen();
    for (int i = 0; i < SCREEN_CELLS; i++) screen_copy[i] = tccs_pkg::BLANK_CHAR;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < SCREEN_CELLS - SCREEN_COLUMNS; i++)
      screen_copy[i] = screen_copy[i + SCREEN_COLUMNS];
    for (int i = SCREEN_CELLS - SCREEN_COLUMNS; i < SCREEN_CELLS; i++)
      screen_copy[i] = tccs_pkg::BLANK_CHAR;
  endfunction

  // Store one glyph (or take a newline) and advance; report whether it scrolled.
  function automatic bit put_glyph(logic [7:0] code);
    if (code == tccs_pkg::NEWLINE_CHAR) begin
      cur_row++;
      cur_col = 0;
    end else begin
      screen_copy[cur_row * SCREEN_COLUMNS + cur_col] = code;
      cur_col++;
    end
    if (cur_col > SCREEN_COLUMNS - 1) begin
      cur_row++;
      cur_col = 0;
    end
    if (cur_row > SCREEN_ROWS - 1) begin
      scroll_screen();
      cur_col = 0;
      cur_row = SCREEN_ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_beat_t predict_command(logic [1:0] k, logic [7:0] code,
                                                    logic [31:0] value, logic [3:0] digits,
                                                    logic [4:0] row, logic [6:0] col);
    console_beat_t r;
    int            n;
    logic [3:0]    nib;
    logic [7:0]    glyph;
    r = '0;
    case (tccs_pkg::kind_t'(k))
      tccs_pkg::KIND_CHAR: begin
        r.scrolled = put_glyph(code);
      end
      tccs_pkg::KIND_HEX: begin
        n = (digits > tccs_pkg::MAX_HEX_DIGITS) ? int'(tccs_pkg::MAX_HEX_DIGITS) :
                                                  int'(digits);
        while (n > 0) begin
          nib   = value[(n - 1) * 4 +: 4];
          glyph = (nib < 4'd10) ? ({4'd0, nib} + tccs_pkg::ASCII_ZERO) :
                                  ({4'd0, nib} + tccs_pkg::ASCII_HEX_BASE);
          if (put_glyph(glyph)) r.scrolled = 1'b1;
          n--;
        end
      end
      tccs_pkg::KIND_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        if (row < SCREEN_ROWS && col < SCREEN_COLUMNS)
          r.read_char = screen_copy[row * SCREEN_COLUMNS + col];
      end
    endcase
    r.row    = 5'(cur_row);
    r.column = 7'(cur_col);
    return r;
  endfunction

  always @(posedge clk) begin : watch_channels
    console_beat_t want;
    if (rst) begin
      blank_screen();
      cur_row    = 0;
      cur_col    = 0;
      mismatches = 0;
      results_due.delete();
    end else begin
      if (in_valid && in_ready)
        results_due.push_back(predict_command(kind, char_code, hex_value, hex_digits,
                                              cell_row, cell_column));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result beat: char %h row %0d col %0d scroll %b",
                   $time, read_char, cursor_row, cursor_column, scrolled);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (want.read_char !== read_char || want.row !== cursor_row ||
              want.column !== cursor_column || want.scrolled !== scrolled) begin
            $display("%0t: mismatch, expected char %h row %0d col %0d scroll %b; got %h %0d %0d %b",
                     $time, want.read_char, want.row, want.column, want.scrolled,
                     read_char, cursor_row, cursor_column, scrolled);
            mismatches++;
          end
        end
      end
    end
    beats_due = results_due.size();
  end

endmodule

FILE: tb/tb_text_console_cursor_scroll_core.sv
// Testbench top for the text console core: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_core;

  // Generous bound: even if every command scrolled under
  // the longest gaps and stalls, the run stays well below this.
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int RANDOM_BEATS = 627;
  // Quiet time after the last result; any stray beat shows up in the checker.
  localparam int DRAIN_CYCLES = 64;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  kind        = tccs_pkg::KIND_CHAR;
  logic [7:0]  char_code   = '0;
  logic [31:0] hex_value   = '0;
  logic [3:0]  hex_digits  = '0;
  logic [4:0]  cell_row    = '0;
  logic [6:0]  cell_column = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  read_char;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_column;
  logic        scrolled;

  int mismatches;
  int beats_due;
  int cycle_count = 0;
  int calm_left   = 0;  // commands left in a run with no sender gaps
  int ready_left  = 0;  // cycles left in the current out_ready pattern

  always #2 clk = ~clk;

  text_console_cursor_scroll_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .char_code    (char_code),
    .hex_value    (hex_value),
    .hex_digits   (hex_digits),
    .cell_row     (cell_row),
    .cell_column  (cell_column),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_char    (read_char),
    .cursor_row   (cursor_row),
    .cursor_column(cursor_column),
    .scrolled     (scrolled)
  );

  text_console_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .char_code    (char_code),
    .hex_value    (hex_value),
    .hex_digits   (hex_digits),
    .cell_row     (cell_row),
    .cell_column  (cell_column),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_char    (read_char),
    .cursor_row   (cursor_row),
    .cursor_column(cursor_column),
    .scrolled     (scrolled),
    .mismatches   (mismatches),
    .beats_due    (beats_due)
  );

  // Bound the run; a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_text_console_cursor_scroll_core: FAIL");
      $finish;
    end
  end

  // Throttle the result side: mostly short stalls, a few long ones, and
  // stretches where out_ready stays high so back-to-back beats drain too.
  always @(negedge clk) begin : ready_pattern
    int roll;
    if (ready_left == 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(1, 8);
      end else if (roll < 65) begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(40, 120);
      end else if (roll < 95) begin
        out_ready <= 1'b0;
        ready_left = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        ready_left = $urandom_range(15, 40);
      end
    end else begin
      ready_left--;
    end
  end

  // Sender gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one command beat at a falling edge and hold it until accepted.
  // Enter and leave at a falling edge; with no gap, in_valid stays high
  // straight into the next beat.
  task automatic send_command(input tccs_pkg::kind_t k, input logic [7:0] code,
                              input logic [31:0] value, input logic [3:0] digits,
                              input logic [4:0] row, input logic [6:0] col);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(20, 60);
      gap = 0;
    end else begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    char_code   <= code;
    hex_value   <= value;
    hex_digits  <= digits;
    cell_row    <= row;
    cell_column <= col;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every expected result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (beats_due != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    tccs_pkg::kind_t k;
    logic [7:0]      code;
    logic [31:0]     value;
    logic [3:0]      digits;
    logic [4:0]      row;
    logic [6:0]      col;
    int              sel;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The block runs its power-up clearing pass first; the
    // first beat simply waits for in_ready.
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd0, 7'd0);  // reset content
    send_command(tccs_pkg::KIND_CHAR, 8'h00, 32'h0, 4'd0, 5'd0, 7'd0);  // code zero is stored
    send_command(tccs_pkg::KIND_CHAR, 8'hFF, 32'h0, 4'd0, 5'd0, 7'd0);
    send_command(tccs_pkg::KIND_CHAR, 8'h41, 32'h0, 4'd0, 5'd0, 7'd0);
    send_command(tccs_pkg::KIND_CHAR, tccs_pkg::NEWLINE_CHAR, 32'h0, 4'd0, 5'd0, 7'd0);
    send_command(tccs_pkg::KIND_HEX, 8'h00, 32'hFEDC_BA98, 4'd8, 5'd0, 7'd0);  // letters A..F
    send_command(tccs_pkg::KIND_HEX, 8'h00, 32'h0123_4567, 4'd8, 5'd0, 7'd0);  // digits 0..7
    send_command(tccs_pkg::KIND_HEX, 8'h00, 32'h0000_000A, 4'd0, 5'd0, 7'd0);  // zero digits
    send_command(tccs_pkg::KIND_HEX, 8'h00, 32'hFFFF_FFFF, 4'd15, 5'd0, 7'd0); // saturates
    send_command(tccs_pkg::KIND_HEX, 8'h00, 32'h89AB_CDEF, 4'd9, 5'd0, 7'd0);
    send_command(tccs_pkg::KIND_HEX, 8'h00, 32'h0000_000C, 4'd1, 5'd0, 7'd0);
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd0, 7'd0);
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd0, 7'd1);
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd0, 7'd2);
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd1, 7'd0);
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd24, 7'd79);  // last cell
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd25, 7'd0);   // row off screen
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd0, 7'd80);   // column off screen
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd31, 7'd127);
    send_command(tccs_pkg::KIND_CLEAR, 8'h00, 32'h0, 4'd0, 5'd0, 7'd0);
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd1, 7'd3);    // blanked by clear
    // Newline from home.
    send_command(tccs_pkg::KIND_CHAR, tccs_pkg::NEWLINE_CHAR, 32'h0, 4'd0, 5'd0, 7'd0);
    send_command(tccs_pkg::KIND_READ, 8'h00, 32'h0, 4'd0, 5'd0, 7'd0);

    // Let everything drain once before the random part.
    wait_for_results();

    // Random part: mostly text lines (printable characters and newlines) and
    // hex dumps, so the cursor wraps, reaches the bottom row and scrolls often;
    // reads sample the whole screen; rare clears; a little raw noise.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      sel    = $urandom_range(0, 999);
      k      = tccs_pkg::KIND_CHAR;
      code   = 8'($urandom_range(8'h20, 8'h7E));
      value  = $urandom();
      digits = 4'($urandom_range(1, 8));
      row    = 5'($urandom_range(0, 24));
      col    = 7'($urandom_range(0, 79));
      if (sel < 520) begin
        if ($urandom_range(0, 9) == 0) code = 8'($urandom_range(0, 255));
      end else if (sel < 660) begin
        code = tccs_pkg::NEWLINE_CHAR;
      end else if (sel < 800) begin
        k = tccs_pkg::KIND_HEX;
      end else if (sel < 940) begin
        k = tccs_pkg::KIND_READ;
        if ($urandom_range(0, 9) == 0) begin
          row = 5'($urandom_range(0, 31));
          col = 7'($urandom_range(0, 127));
        end
      end else if (sel < 948) begin
        k = tccs_pkg::KIND_CLEAR;
      end else begin
        k      = tccs_pkg::kind_t'($urandom_range(0, 3));
        code   = 8'($urandom_range(0, 255));
        digits = 4'($urandom_range(0, 15));
        row    = 5'($urandom_range(0, 31));
        col    = 7'($urandom_range(0, 127));
      end
      // Halfway through, hold off the sender again until the block is empty.
      if (n == RANDOM_BEATS / 2) wait_for_results();
      send_command(k, code, value, digits, row, col);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("tb_text_console_cursor_scroll_core: PASS");
    end else begin
      $display("tb_text_console_cursor_scroll_core: FAIL");
    end
    $finish;
  end

endmodule
